FILE: hw/rtl/qfts_pkg.sv
package qfts_pkg;

  localparam int unsigned DataW = 32;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XFER,
    ST_POP
  } state_e;

  typedef struct packed {
    logic                    operation;
    logic signed [DataW-1:0] value_in;
  } cmd_t;

  typedef struct packed {
    logic                    ok;
    logic signed [DataW-1:0] value_out;
  } res_t;

endpackage

FILE: hw/rtl/queue_from_two_stacks.sv
// FIFO queue of signed 32-bit elements built from an input stack and an output stack, each
// STACK_DEPTH entries deep and each held in its own single-port synchronous RAM. A command
// is taken when start_i is high and busy_o is low; its result appears on res_o for exactly
// one cycle with done_o high, and the receiver cannot stall it. An enqueue that fits, or
// one that is refused, keeps busy_o low and the next command may follow at once. A dequeue
// from a non-empty output stack keeps busy_o high in ST_POP while the RAM read returns. When
// a dequeue finds the output stack empty, or an enqueue finds the input stack full and the
// output stack empty, the input stack is first copied across, one RAM read and one RAM write
// per element; each element is copied across only once.
module queue_from_two_stacks #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  qfts_pkg::cmd_t cmd_i,
  output logic          busy_o,
  output logic          done_o,
  output qfts_pkg::res_t res_o
);
  import qfts_pkg::*;

  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  state_e state_q, state_d;
  logic [CntW-1:0] in_cnt_q, in_cnt_d;
  logic [CntW-1:0] out_cnt_q, out_cnt_d;
  logic            rdv_q, rdv_d;
  logic            op_q, op_d;
  logic signed [DataW-1:0] val_q, val_d;
  logic            done_q, done_d;
  res_t            res_q, res_d;

  logic [DataW-1:0] in_mem  [STACK_DEPTH];
  logic [DataW-1:0] out_mem [STACK_DEPTH];
  logic [DataW-1:0] in_rdata_q, out_rdata_q;

  logic             in_we, in_re, out_we, out_re;
  logic [AddrW-1:0] in_waddr, in_raddr, out_waddr, out_raddr;
  logic [DataW-1:0] in_wdata;
  logic [CntW-1:0]  in_top, out_top;

  assign in_top    = in_cnt_q - CntOne;
  assign out_top   = out_cnt_q - CntOne;
  assign in_raddr  = in_top[AddrW-1:0];
  assign out_raddr = out_top[AddrW-1:0];
  assign out_waddr = out_cnt_q[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_we) begin
      in_mem[in_waddr] <= in_wdata;
    end
    if (in_re) begin
      in_rdata_q <= in_mem[in_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_we) begin
      out_mem[out_waddr] <= in_rdata_q;
    end
    if (out_re) begin
      out_rdata_q <= out_mem[out_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      rdv_q     <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      in_cnt_q  <= in_cnt_d;
      out_cnt_q <= out_cnt_d;
      rdv_q     <= rdv_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    val_q <= val_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d   = state_q;
    in_cnt_d  = in_cnt_q;
    out_cnt_d = out_cnt_q;
    rdv_d     = 1'b0;
    op_d      = op_q;
    val_d     = val_q;
    done_d    = 1'b0;
    res_d     = '0;
    in_we     = 1'b0;
    in_waddr  = in_cnt_q[AddrW-1:0];
    in_wdata  = cmd_i.value_in;
    in_re     = 1'b0;
    out_we    = 1'b0;
    out_re    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d  = cmd_i.operation;
          val_d = cmd_i.value_in;
          if (cmd_i.operation == OP_ENQUEUE) begin
            priority if (in_cnt_q != CntFull) begin
              in_we    = 1'b1;
              in_cnt_d = in_cnt_q + CntOne;
              done_d   = 1'b1;
              res_d.ok = 1'b1;
            end else if (out_cnt_q == '0) begin
              state_d = ST_XFER;
            end else begin
              done_d = 1'b1;
            end
          end else begin
            priority if (out_cnt_q != '0) begin
              out_re    = 1'b1;
              out_cnt_d = out_top;
              state_d   = ST_POP;
            end else if (in_cnt_q != '0) begin
              state_d = ST_XFER;
            end else begin
              done_d = 1'b1;
            end
          end
        end
      end
      ST_XFER: begin
        if (rdv_q) begin
          out_we    = 1'b1;
          out_cnt_d = out_cnt_q + CntOne;
        end
        priority if (in_cnt_q != '0) begin
          in_re    = 1'b1;
          in_cnt_d = in_top;
          rdv_d    = 1'b1;
        end else if (rdv_q) begin
          state_d = ST_XFER;
        end else if (op_q == OP_ENQUEUE) begin
          in_we    = 1'b1;
          in_wdata = val_q;
          in_cnt_d = CntOne;
          done_d   = 1'b1;
          res_d.ok = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          out_re    = 1'b1;
          out_cnt_d = out_top;
          state_d   = ST_POP;
        end
      end
      ST_POP: begin
        done_d          = 1'b1;
        res_d.ok        = 1'b1;
        res_d.value_out = out_rdata_q;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: hw/rtl/qfts_checker.sv
module qfts_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input qfts_pkg::cmd_t cmd_i,
  input logic           busy_o,
  input logic           done_o,
  input qfts_pkg::res_t res_o
);

  // every beat taken either finishes next cycle or holds the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || done_o)
    else $error("accepted beat neither finished nor held busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result beat while still busy");

  a_busy_ends_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result beat");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.ok |-> res_o.value_out == '0)
    else $error("refused beat carries a nonzero value");

endmodule

bind queue_from_two_stacks qfts_checker u_qfts_checker (.*);
